@@ rtl/two_pkg.sv @@
// shared types, codes and the multiply-accumulate schedule of the winding orienter
`timescale 1ns / 1ps

package two_pkg;

	// fixed field widths
	localparam int IDX_W    = 12;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
	localparam logic [OP_W-1:0] OP_ORIENT = 2'd2;

	// face status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// digit width of the shared multiplier
	localparam int DIGIT_W = 8;

	// centroid offset is taken against three times the coordinate sum
	localparam int CENTROID_SCALE = 3;

	// schedule length
	localparam int STEP_W = 4;
	localparam int NSTEPS = 15;

	typedef logic [3:0] asel_t;
	typedef logic [2:0] bsel_t;
	typedef logic [2:0] dest_t;

	// first operand sources
	localparam asel_t A_E1X = 4'd0;
	localparam asel_t A_E1Y = 4'd1;
	localparam asel_t A_E1Z = 4'd2;
	localparam asel_t A_PSX = 4'd3;
	localparam asel_t A_PSY = 4'd4;
	localparam asel_t A_PSZ = 4'd5;
	localparam asel_t A_SX  = 4'd6;
	localparam asel_t A_SY  = 4'd7;
	localparam asel_t A_SZ  = 4'd8;
	localparam asel_t A_CX  = 4'd9;
	localparam asel_t A_CY  = 4'd10;
	localparam asel_t A_CZ  = 4'd11;

	// second operand sources
	localparam bsel_t B_E2X   = 3'd0;
	localparam bsel_t B_E2Y   = 3'd1;
	localparam bsel_t B_E2Z   = 3'd2;
	localparam bsel_t B_NCNT  = 3'd3;
	localparam bsel_t B_SCALE = 3'd4;
	localparam bsel_t B_DX    = 3'd5;
	localparam bsel_t B_DY    = 3'd6;
	localparam bsel_t B_DZ    = 3'd7;

	// where a finished sum goes
	localparam dest_t DST_NONE = 3'd0;
	localparam dest_t DST_CX   = 3'd1;
	localparam dest_t DST_CY   = 3'd2;
	localparam dest_t DST_CZ   = 3'd3;
	localparam dest_t DST_DX   = 3'd4;
	localparam dest_t DST_DY   = 3'd5;
	localparam dest_t DST_DZ   = 3'd6;
	localparam dest_t DST_DOT  = 3'd7;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		logic  neg;
		logic  first;
		dest_t dest;
	} uop_t;

	typedef struct packed {
		logic load;
		logic step;
		logic accum;
		logic first;
		logic neg;
	} mac_ctl_t;

	// one product per step: cross product, centroid offsets, then the dot
	function automatic uop_t two_uop(input logic [STEP_W-1:0] step);
		uop_t u;
		unique case (step)
			4'd0:    u = '{A_E1Y, B_E2Z,   1'b0, 1'b1, DST_NONE};
			4'd1:    u = '{A_E1Z, B_E2Y,   1'b1, 1'b0, DST_CX};
			4'd2:    u = '{A_E1Z, B_E2X,   1'b0, 1'b1, DST_NONE};
			4'd3:    u = '{A_E1X, B_E2Z,   1'b1, 1'b0, DST_CY};
			4'd4:    u = '{A_E1X, B_E2Y,   1'b0, 1'b1, DST_NONE};
			4'd5:    u = '{A_E1Y, B_E2X,   1'b1, 1'b0, DST_CZ};
			4'd6:    u = '{A_PSX, B_NCNT,  1'b0, 1'b1, DST_NONE};
			4'd7:    u = '{A_SX,  B_SCALE, 1'b1, 1'b0, DST_DX};
			4'd8:    u = '{A_PSY, B_NCNT,  1'b0, 1'b1, DST_NONE};
			4'd9:    u = '{A_SY,  B_SCALE, 1'b1, 1'b0, DST_DY};
			4'd10:   u = '{A_PSZ, B_NCNT,  1'b0, 1'b1, DST_NONE};
			4'd11:   u = '{A_SZ,  B_SCALE, 1'b1, 1'b0, DST_DZ};
			4'd12:   u = '{A_CX,  B_DX,    1'b0, 1'b1, DST_NONE};
			4'd13:   u = '{A_CY,  B_DY,    1'b0, 1'b0, DST_NONE};
			4'd14:   u = '{A_CZ,  B_DZ,    1'b0, 1'b0, DST_DOT};
			default: u = '{A_E1X, B_E2X,   1'b0, 1'b1, DST_NONE};
		endcase
		return u;
	endfunction

endpackage

@@ rtl/two_if.sv @@
// valid/ready channel interfaces for face and vertex words and for result words
`timescale 1ns / 1ps

interface two_item_if #(parameter int COORD_WIDTH = 24);
	import two_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [OP_W-1:0]               opcode;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic [IDX_W-1:0]              index_a;
	logic [IDX_W-1:0]              index_b;
	logic [IDX_W-1:0]              index_c;

	modport source (
		output valid, opcode, coord_x, coord_y, coord_z, index_a, index_b, index_c,
		input  ready
	);
	modport sink (
		input  valid, opcode, coord_x, coord_y, coord_z, index_a, index_b, index_c,
		output ready
	);
endinterface

interface two_result_if;
	import two_pkg::*;

	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    out_index_a;
	logic [IDX_W-1:0]    out_index_b;
	logic [IDX_W-1:0]    out_index_c;
	logic                flipped;
	logic [STATUS_W-1:0] status;
	logic                vertex_overflow;

	modport source (
		output valid, out_index_a, out_index_b, out_index_c, flipped, status,
		       vertex_overflow,
		input  ready
	);
	modport sink (
		input  valid, out_index_a, out_index_b, out_index_c, flipped, status,
		       vertex_overflow,
		output ready
	);
endinterface

@@ rtl/triangle_winding_orienter.sv @@
// Triangle winding orienter top level. Opcode clear resets the vertex count,
// the coordinate sums and the overflow flag; load writes one vertex at the
// next free entry (a load into a full store is dropped and sets
// vertex_overflow); neither gives a result word. Orient reads the three
// vertices from the single-port store, then one shared 8-bit-digit
// multiplier works through fifteen products (the cross product of the edges,
// the scaled centre offsets N*(v0+v1+v2)-3*S, and their dot), each over ND
// digits, ND = ceil((COORD_WIDTH + clog2(VERTEX_DEPTH) + 3) / 8); no new word
// is taken until the face is done. Faces with no vertex loaded or an index at
// or above the vertex count skip the store and return unchanged, with status
// set. The result sits in an output register, so a new word is taken while it
// waits. Vertex memory is not cleared; no entry at or above the count is ever
// read.
`timescale 1ns / 1ps

module triangle_winding_orienter #(
	parameter int VERTEX_DEPTH = 4096,
	parameter int COORD_WIDTH  = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	two_item_if.sink     items,
	two_result_if.source results
);
	import two_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int AW   = $clog2(VERTEX_DEPTH);
	localparam int CW   = $clog2(VERTEX_DEPTH + 1);
	localparam int SW   = W + AW;
	localparam int EW   = W + 1;
	localparam int PSW  = W + 2;
	localparam int CRW  = 2 * W + 2;
	localparam int DW   = W + AW + 3;
	localparam int MA   = (CRW > SW) ? CRW : SW;
	localparam int ND   = (DW + DIGIT_W - 1) / DIGIT_W;
	localparam int BWID = ND * DIGIT_W;
	localparam int ACW  = MA + BWID + 2;
	localparam int CMPW = (IDX_W > CW) ? IDX_W : CW;
	localparam int DCW  = $clog2(ND);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]           state_q;
	logic [1:0]           rd_cnt_q;
	logic [DCW-1:0]       dig_cnt_q;
	logic [STEP_W-1:0]    step_q;
	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic                 ovf_q;
	logic                 out_valid_q;

	logic [IDX_W-1:0]     ia_q, ib_q, ic_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 flip_q;
	logic [3*W-1:0]       p0_q, p1_q, p2_q;
	logic signed [CRW-1:0] cx_q, cy_q, cz_q;
	logic signed [DW-1:0] dx_q, dy_q, dz_q;

	logic [IDX_W-1:0]     res_a_q, res_b_q, res_c_q;
	logic                 res_flip_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 res_ovf_q;

	logic                 item_fire, out_fire, out_load;
	logic                 store_full;
	logic [STATUS_W-1:0]  face_status;
	logic signed [W-1:0]  in_x, in_y, in_z;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_addr;
	logic [3*W-1:0]       mem_rdata;
	logic [IDX_W-1:0]     rd_idx;

	logic signed [W-1:0]   p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
	logic signed [EW-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [PSW-1:0] psx, psy, psz;
	uop_t                  uop;
	mac_ctl_t              mac_ctl;
	logic signed [MA-1:0]  a_mux;
	logic signed [BWID-1:0] b_mux;
	logic signed [ACW-1:0] acc_sum;

	// handshakes
	assign items.ready = (state_q == S_IDLE);
	assign item_fire   = items.valid && items.ready;
	assign out_fire    = results.valid && results.ready;
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || results.ready);
	assign store_full  = (count_q == CW'(VERTEX_DEPTH));

	assign in_x = W'($signed(items.coord_x));
	assign in_y = W'($signed(items.coord_y));
	assign in_z = W'($signed(items.coord_z));

	// face checks against the current count
	always_comb begin
		if (count_q == '0) begin
			face_status = ST_EMPTY;
		end else if (CMPW'(items.index_a) >= CMPW'(count_q) ||
		             CMPW'(items.index_b) >= CMPW'(count_q) ||
		             CMPW'(items.index_c) >= CMPW'(count_q)) begin
			face_status = ST_RANGE;
		end else begin
			face_status = ST_OK;
		end
	end

	// vertex store port
	always_comb begin
		case (rd_cnt_q)
			2'd0:    rd_idx = ia_q;
			2'd1:    rd_idx = ib_q;
			default: rd_idx = ic_q;
		endcase
	end

	assign mem_we   = item_fire && (items.opcode == OP_LOAD) && !store_full;
	assign mem_re   = (state_q == S_READ) && (rd_cnt_q != 2'd3);
	assign mem_addr = mem_we ? count_q[AW-1:0] : AW'(rd_idx);

	two_vertex_store #(
		.DEPTH  (VERTEX_DEPTH),
		.DATA_W (3 * W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata ({in_x, in_y, in_z}),
		.rdata (mem_rdata)
	);

	// edges and coordinate sums of the face
	assign p0x = $signed(p0_q[3*W-1 -: W]);
	assign p0y = $signed(p0_q[2*W-1 -: W]);
	assign p0z = $signed(p0_q[W-1:0]);
	assign p1x = $signed(p1_q[3*W-1 -: W]);
	assign p1y = $signed(p1_q[2*W-1 -: W]);
	assign p1z = $signed(p1_q[W-1:0]);
	assign p2x = $signed(p2_q[3*W-1 -: W]);
	assign p2y = $signed(p2_q[2*W-1 -: W]);
	assign p2z = $signed(p2_q[W-1:0]);

	assign e1x = EW'(p1x) - EW'(p0x);
	assign e1y = EW'(p1y) - EW'(p0y);
	assign e1z = EW'(p1z) - EW'(p0z);
	assign e2x = EW'(p2x) - EW'(p0x);
	assign e2y = EW'(p2y) - EW'(p0y);
	assign e2z = EW'(p2z) - EW'(p0z);

	assign psx = PSW'(p0x) + PSW'(p1x) + PSW'(p2x);
	assign psy = PSW'(p0y) + PSW'(p1y) + PSW'(p2y);
	assign psz = PSW'(p0z) + PSW'(p1z) + PSW'(p2z);

	// operand selection for the current step
	assign uop = two_uop(step_q);

	always_comb begin
		case (uop.asel)
			A_E1X:   a_mux = MA'(e1x);
			A_E1Y:   a_mux = MA'(e1y);
			A_E1Z:   a_mux = MA'(e1z);
			A_PSX:   a_mux = MA'(psx);
			A_PSY:   a_mux = MA'(psy);
			A_PSZ:   a_mux = MA'(psz);
			A_SX:    a_mux = MA'(sum_x_q);
			A_SY:    a_mux = MA'(sum_y_q);
			A_SZ:    a_mux = MA'(sum_z_q);
			A_CX:    a_mux = MA'(cx_q);
			A_CY:    a_mux = MA'(cy_q);
			A_CZ:    a_mux = MA'(cz_q);
			default: a_mux = '0;
		endcase
	end

	always_comb begin
		case (uop.bsel)
			B_E2X:   b_mux = BWID'(e2x);
			B_E2Y:   b_mux = BWID'(e2y);
			B_E2Z:   b_mux = BWID'(e2z);
			B_NCNT:  b_mux = BWID'(count_q);
			B_SCALE: b_mux = BWID'(CENTROID_SCALE);
			B_DX:    b_mux = BWID'(dx_q);
			B_DY:    b_mux = BWID'(dy_q);
			default: b_mux = BWID'(dz_q);
		endcase
	end

	assign mac_ctl.load  = (state_q == S_LOAD);
	assign mac_ctl.step  = (state_q == S_MUL);
	assign mac_ctl.accum = (state_q == S_ACC);
	assign mac_ctl.first = uop.first;
	assign mac_ctl.neg   = uop.neg;

	two_mac #(
		.A_W   (MA),
		.B_W   (BWID),
		.ACC_W (ACW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.a_in    (a_mux),
		.b_in    (b_mux),
		.acc_sum (acc_sum)
	);

	// sequencer and mesh state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			dig_cnt_q   <= '0;
			step_q      <= '0;
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						case (items.opcode)
							OP_CLEAR: begin
								count_q <= '0;
								sum_x_q <= '0;
								sum_y_q <= '0;
								sum_z_q <= '0;
								ovf_q   <= 1'b0;
							end
							OP_LOAD: begin
								if (store_full) begin
									ovf_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
									sum_x_q <= sum_x_q + SW'(in_x);
									sum_y_q <= sum_y_q + SW'(in_y);
									sum_z_q <= sum_z_q + SW'(in_z);
								end
							end
							OP_ORIENT: begin
								rd_cnt_q <= '0;
								state_q  <= (face_status == ST_OK) ? S_READ : S_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 2'd3) begin
						step_q  <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					dig_cnt_q <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					dig_cnt_q <= dig_cnt_q + 1'b1;
					if (dig_cnt_q == DCW'(ND - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (step_q == STEP_W'(NSTEPS - 1)) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// face payload, vertex shift line, intermediate sums and result word
	always_ff @(posedge clk) begin
		if (item_fire && items.opcode == OP_ORIENT) begin
			ia_q     <= items.index_a;
			ib_q     <= items.index_b;
			ic_q     <= items.index_c;
			status_q <= face_status;
			flip_q   <= 1'b0;
		end
		if (state_q == S_READ && rd_cnt_q != 2'd0) begin
			p0_q <= p1_q;
			p1_q <= p2_q;
			p2_q <= mem_rdata;
		end
		if (state_q == S_ACC) begin
			case (uop.dest)
				DST_CX:  cx_q <= CRW'(acc_sum);
				DST_CY:  cy_q <= CRW'(acc_sum);
				DST_CZ:  cz_q <= CRW'(acc_sum);
				DST_DX:  dx_q <= DW'(acc_sum);
				DST_DY:  dy_q <= DW'(acc_sum);
				DST_DZ:  dz_q <= DW'(acc_sum);
				DST_DOT: flip_q <= acc_sum[ACW-1];
				default: begin
				end
			endcase
		end
		if (out_load) begin
			res_a_q      <= ia_q;
			res_b_q      <= flip_q ? ic_q : ib_q;
			res_c_q      <= flip_q ? ib_q : ic_q;
			res_flip_q   <= flip_q;
			res_status_q <= status_q;
			res_ovf_q    <= ovf_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.out_index_a     = res_a_q;
	assign results.out_index_b     = res_b_q;
	assign results.out_index_c     = res_c_q;
	assign results.flipped         = res_flip_q;
	assign results.status          = res_status_q;
	assign results.vertex_overflow = res_ovf_q;

	// overflow only ever follows a full store
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> store_full)
		else $error("overflow flag set while store not full");

	// count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(VERTEX_DEPTH))
		else $error("vertex count beyond store depth");

	// every accumulate follows the last digit of a product
	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> ($past(state_q) == S_MUL &&
		                        $past(dig_cnt_q) == DCW'(ND - 1)))
		else $error("accumulate without a finished product");

	// a new result word only comes out of the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result word raised outside the done state");

	// schedule index stays within the program
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(NSTEPS))
		else $error("schedule step out of range");

endmodule

@@ rtl/two_vertex_store.sv @@
// single-port vertex memory with registered read data
`timescale 1ns / 1ps

module two_vertex_store #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	// one access per cycle, write or read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ rtl/two_mac.sv @@
// shared digit-serial multiplier with product register and signed accumulator
`timescale 1ns / 1ps

module two_mac #(
	parameter int A_W   = 50,
	parameter int B_W   = 40,
	parameter int ACC_W = 92
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  two_pkg::mac_ctl_t       ctl,
	input  logic signed [A_W-1:0]   a_in,
	input  logic signed [B_W-1:0]   b_in,
	output logic signed [ACC_W-1:0] acc_sum
);
	import two_pkg::*;

	localparam int PW = A_W + B_W;

	logic signed [A_W-1:0]       opa_q;
	logic [B_W-1:0]              opb_q;
	logic                        msd_q;
	logic signed [PW-1:0]        prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [DIGIT_W-1:0]          digit;
	logic signed [DIGIT_W:0]     dig_s;
	logic signed [A_W+DIGIT_W:0] pp;
	logic signed [PW-1:0]        prod_next;
	logic signed [ACC_W-1:0]     addend;

	// top digit carries the sign, lower digits are unsigned
	assign digit = opb_q[B_W-1 -: DIGIT_W];
	assign dig_s = msd_q ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
	assign pp    = opa_q * dig_s;

	// horner step, most significant digit first
	assign prod_next = (prod_q <<< DIGIT_W) + PW'(pp);

	// accumulate the finished product
	assign addend  = ctl.neg ? -ACC_W'(prod_q) : ACC_W'(prod_q);
	assign acc_sum = (ctl.first ? '0 : acc_q) + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msd_q <= 1'b0;
		end else if (ctl.load) begin
			msd_q <= 1'b1;
		end else if (ctl.step) begin
			msd_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			opa_q  <= a_in;
			opb_q  <= b_in;
			prod_q <= '0;
		end else if (ctl.step) begin
			opb_q  <= opb_q << DIGIT_W;
			prod_q <= prod_next;
		end
		if (ctl.accum) begin
			acc_q <= acc_sum;
		end
	end

endmodule

@@ tb/sv/tb_triangle_winding_orienter.sv @@
// testbench for the winding orienter: directed and random vertex/face words checked against a predictor
`timescale 1ns / 1ps

module tb_triangle_winding_orienter;
	import two_pkg::*;

	localparam int DEPTH        = 4096;
	localparam int CW           = 24;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 250;
	localparam int RANDOM_ITEMS = 750;

	// opcode the block ignores
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

	typedef struct packed {
		logic [IDX_W-1:0]    a;
		logic [IDX_W-1:0]    b;
		logic [IDX_W-1:0]    c;
		logic                flipped;
		logic [STATUS_W-1:0] status;
		logic                overflow;
	} face_word_t;

	// mesh state, face orientation and the queue of faces still due
	class face_orient_checker;
		longint     vtx[DEPTH][3];
		int         count;
		longint     sum[3];
		bit         overflow;
		face_word_t expected_faces[$];
		int         errors;

		function new();
			clear_mesh();
			errors = 0;
		endfunction

		function void clear_mesh();
			count = 0;
			sum = '{0, 0, 0};
			overflow = 1'b0;
		endfunction

		// exact sign of dot(normal, 3N * (face centre - centroid))
		function face_word_t orient_face(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
				logic [IDX_W-1:0] c);
			face_word_t w;
			logic signed [127:0] e1[3];
			logic signed [127:0] e2[3];
			logic signed [127:0] off[3];
			logic signed [127:0] nrm[3];
			logic signed [127:0] dot;
			longint n;
			int k;
			w.a = a;
			w.b = b;
			w.c = c;
			w.flipped = 1'b0;
			w.status = ST_OK;
			w.overflow = overflow;
			n = longint'(count);
			if (count == 0) begin
				w.status = ST_EMPTY;
			end else if (a >= count || b >= count || c >= count) begin
				w.status = ST_RANGE;
			end else begin
				for (k = 0; k < 3; k++) begin
					e1[k] = 128'(vtx[b][k] - vtx[a][k]);
					e2[k] = 128'(vtx[c][k] - vtx[a][k]);
					off[k] = 128'(n * (vtx[a][k] + vtx[b][k] + vtx[c][k]) - 3 * sum[k]);
				end
				nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
				nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
				nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
				dot = nrm[0] * off[0] + nrm[1] * off[1] + nrm[2] * off[2];
				if (dot < 0) begin
					w.b = c;
					w.c = b;
					w.flipped = 1'b1;
				end
			end
			return w;
		endfunction

		// update the mesh for an accepted word and queue any face result
		function void note_word(logic [OP_W-1:0] op, logic signed [CW-1:0] x,
				logic signed [CW-1:0] y, logic signed [CW-1:0] z,
				logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, logic [IDX_W-1:0] c);
			case (op)
				OP_CLEAR: begin
					clear_mesh();
				end
				OP_LOAD: begin
					if (count >= DEPTH) begin
						overflow = 1'b1;
					end else begin
						vtx[count][0] = longint'(x);
						vtx[count][1] = longint'(y);
						vtx[count][2] = longint'(z);
						sum[0] += longint'(x);
						sum[1] += longint'(y);
						sum[2] += longint'(z);
						count++;
					end
				end
				OP_ORIENT: begin
					expected_faces = {expected_faces, orient_face(a, b, c)};
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		// compare a delivered face with the oldest one due
		task check_word(face_word_t got);
			face_word_t want;
			if (expected_faces.size() == 0) begin
				report($sformatf("face word %0d %0d %0d with nothing due", got.a, got.b, got.c));
			end else begin
				want = expected_faces.pop_front();
				if (got.a != want.a)
					report($sformatf("out_index_a got %0d want %0d", got.a, want.a));
				if (got.b != want.b)
					report($sformatf("out_index_b got %0d want %0d", got.b, want.b));
				if (got.c != want.c)
					report($sformatf("out_index_c got %0d want %0d", got.c, want.c));
				if (got.flipped != want.flipped)
					report($sformatf("flipped got %0d want %0d", got.flipped, want.flipped));
				if (got.status != want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.overflow != want.overflow)
					report($sformatf("vertex_overflow got %0d want %0d", got.overflow,
						want.overflow));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	two_item_if #(.COORD_WIDTH(CW)) items ();
	two_result_if results ();

	triangle_winding_orienter #(
		.VERTEX_DEPTH(DEPTH),
		.COORD_WIDTH (CW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results)
	);

	face_orient_checker winding = new();

	bit calm = 1'b0;
	int sent_items = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// known input values from the start
	initial begin
		items.valid = 1'b0;
		items.opcode = OP_CLEAR;
		items.coord_x = '0;
		items.coord_y = '0;
		items.coord_z = '0;
		items.index_a = '0;
		items.index_b = '0;
		items.index_c = '0;
		results.ready = 1'b0;
	end

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return CW'($urandom);
		if (r < 75)
			return CW'(int'($urandom_range(0, 200)) - 100);
		if (r < 85)
			return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
		return CW'(int'($urandom_range(0, 4)) - 2);
	endfunction

	// result ready with random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (stall_left > 0) begin
			results.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			results.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			results.ready <= 1'b1;
		end
	end

	// take result words
	always @(posedge clk) begin
		face_word_t got;
		if (arst_n && results.valid && results.ready) begin
			got.a = results.out_index_a;
			got.b = results.out_index_b;
			got.c = results.out_index_c;
			got.flipped = results.flipped;
			got.status = results.status;
			got.overflow = results.vertex_overflow;
			winding.check_word(got);
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (items.valid && items.ready) || (results.valid && results.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// drive one word; entered and left at a falling edge
	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
			input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
			input logic [IDX_W-1:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.valid <= 1'b1;
		items.opcode <= op;
		items.coord_x <= x;
		items.coord_y <= y;
		items.coord_z <= z;
		items.index_a <= a;
		items.index_b <= b;
		items.index_c <= c;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		winding.note_word(op, x, y, z, a, b, c);
		if (op != OP_UNUSED)
			sent_items++;
		@(negedge clk);
	endtask

	task automatic load_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] z);
		send_word(OP_LOAD, x, y, z, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic orient(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
			input logic [IDX_W-1:0] c);
		send_word(OP_ORIENT, CW'($urandom), CW'($urandom), CW'($urandom), a, b, c);
	endtask

	task automatic clear_mesh();
		send_word(OP_CLEAR, CW'($urandom), CW'($urandom), CW'($urandom),
			IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic unused_word();
		send_word(OP_UNUSED, CW'($urandom), CW'($urandom), CW'($urandom),
			IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// sender holds off until every face has come back
	task automatic hold_until_drained();
		items.valid <= 1'b0;
		do
			@(negedge clk);
		while (winding.expected_faces.size() != 0);
	endtask

	// one word: mostly valid faces, some degenerate or out of range, else a vertex load or noise
	task automatic random_face();
		int n;
		int r;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		n = winding.count;
		r = $urandom_range(0, 99);
		a = IDX_W'($urandom);
		b = IDX_W'($urandom);
		c = IDX_W'($urandom);
		if (n > 0) begin
			a = IDX_W'($urandom_range(0, n - 1));
			b = IDX_W'($urandom_range(0, n - 1));
			c = IDX_W'($urandom_range(0, n - 1));
		end
		if (n == 0 || r < 70) begin
			orient(a, b, c);
		end else if (r < 82) begin
			// repeated vertex gives a zero normal
			if ($urandom_range(0, 1) != 0)
				orient(a, a, c);
			else
				orient(a, b, b);
		end else if (r < 92) begin
			if (n < DEPTH) begin
				case ($urandom_range(0, 2))
					0: a = IDX_W'($urandom_range(n, DEPTH - 1));
					1: b = IDX_W'($urandom_range(n, DEPTH - 1));
					default: c = IDX_W'($urandom_range(n, DEPTH - 1));
				endcase
			end
			orient(a, b, c);
		end else if (r < 96) begin
			load_vertex(rand_coord(), rand_coord(), rand_coord());
		end else begin
			unused_word();
		end
	endtask

	initial begin
		int target;
		int k;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty mesh, extremes, both windings, degenerate and range cases
		orient(0, 0, 0);
		orient(4095, 4095, 4095);
		unused_word();
		clear_mesh();
		load_vertex(C_MIN, C_MIN, C_MIN);
		load_vertex(C_MAX, C_MIN, C_MIN);
		load_vertex(C_MIN, C_MAX, C_MIN);
		load_vertex(C_MIN, C_MIN, C_MAX);
		orient(0, 1, 2);
		orient(0, 2, 1);
		orient(1, 2, 3);
		orient(1, 3, 2);
		orient(0, 0, 1);
		orient(2, 2, 2);
		orient(0, 1, 4);
		orient(4095, 0, 1);
		orient(0, 4095, 1);
		orient(0, 1, 4095);
		unused_word();
		orient(3, 1, 0);
		hold_until_drained();
		clear_mesh();
		orient(0, 1, 2);
		load_vertex(1, 0, 0);
		load_vertex(0, 1, 0);
		load_vertex(0, 0, 1);
		orient(0, 1, 2);
		orient(0, 2, 1);

		// fill the store, overflow it, then clear
		clear_mesh();
		repeat (DEPTH) load_vertex(rand_coord(), rand_coord(), rand_coord());
		repeat (3) load_vertex(rand_coord(), rand_coord(), rand_coord());
		orient(4095, 0, 2048);
		orient(4095, 4094, 4093);
		repeat (10) random_face();
		clear_mesh();
		orient(0, 0, 0);
		hold_until_drained();

		// random mesh sequences
		target = sent_items + RANDOM_ITEMS;
		while (sent_items < target) begin
			calm = ($urandom_range(0, 5) == 0);
			if (winding.count > 3000 || $urandom_range(0, 4) != 0)
				clear_mesh();
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			repeat (k) load_vertex(rand_coord(), rand_coord(), rand_coord());
			repeat ($urandom_range(2, 8)) random_face();
			if ($urandom_range(0, 9) == 0)
				hold_until_drained();
		end
		calm = 1'b0;
		items.valid <= 1'b0;

		// drain and let the block settle
		while (winding.expected_faces.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (winding.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/two_pkg.sv
rtl/two_if.sv
rtl/two_vertex_store.sv
rtl/two_mac.sv
rtl/triangle_winding_orienter.sv
tb/sv/tb_triangle_winding_orienter.sv
